// ===== sv/rcam_pkg.sv =====
// Shared types and constants for the rounded-corner alpha mask unit.
package rcam_pkg;

  localparam int COORD_W  = 8;    // pixel column / row width
  localparam int RAD_CFG_W = 9;   // radius register width
  localparam int OFS_W    = 11;   // signed offset from the circle center
  localparam int SQ_W     = 18;   // one squared offset
  localparam int SUM_W    = 19;   // sum of both squared offsets
  localparam int FRAC_W   = 16;   // left shift applied before the square root
  localparam int ROOT_W   = 18;   // 10.8 distance, one root bit per cell
  localparam int RADC_W   = 2 * ROOT_W;  // radicand width, two bits per cell
  localparam int REM_W    = ROOT_W + 2;  // partial remainder width
  localparam int BASE_W   = RAD_CFG_W + 8;  // 127 + (radius << 8)
  localparam int ALPHA_W  = 8;
  localparam int N_CELLS  = ROOT_W;

  localparam logic [7:0] ALPHA_BIAS = 8'd127;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  // Valid flag of one pipeline slot.
  typedef struct packed {
    logic valid;
  } slot_ctl_t;

  // Payload handed from one square-root cell to the next.
  typedef struct packed {
    logic [RADC_W-1:0] radc;   // radicand bits not yet consumed, MSB first
    logic [REM_W-1:0]  rem;    // partial remainder
    logic [ROOT_W-1:0] root;   // partial root
    logic [BASE_W-1:0] base;   // 127 + (radius << 8), carried along
  } cell_data_t;

endpackage

// ===== sv/rcam_front.sv =====
// Offset, squaring and summing stages ahead of the square-root chain.
module rcam_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               take,
  input  logic [rcam_pkg::COORD_W-1:0]       col,
  input  logic [rcam_pkg::COORD_W-1:0]       row,
  input  logic [rcam_pkg::RAD_CFG_W-1:0]     r_eff,
  output rcam_pkg::slot_ctl_t                ctl_o,
  output rcam_pkg::cell_data_t               data_o
);

  // Stage A: signed offsets from the center at (r-1, r-1).
  logic                                  a_valid_r;
  logic signed [rcam_pkg::OFS_W-1:0]     dx_r, dy_r, dx_nxt, dy_nxt;
  logic [rcam_pkg::BASE_W-1:0]           a_base_r, a_base_nxt;
  // Stage B: squared offsets.
  logic                                  b_valid_r;
  logic [rcam_pkg::SQ_W-1:0]             sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [rcam_pkg::BASE_W-1:0]           b_base_r;
  logic signed [2*rcam_pkg::OFS_W-1:0]   px, py;
  // Stage C: sum, shifted into the radicand.
  logic                                  c_valid_r;
  logic [rcam_pkg::SUM_W-1:0]            sum_nxt;
  rcam_pkg::cell_data_t                  c_data_r, c_data_nxt;

  always_comb begin
    dx_nxt = $signed({2'b00, r_eff}) - 11'sd1 - $signed({3'b000, col});
    dy_nxt = $signed({2'b00, r_eff}) - 11'sd1 - $signed({3'b000, row});
    a_base_nxt = {r_eff, rcam_pkg::ALPHA_BIAS};
  end

  always_comb begin
    px = dx_r * dx_r;
    py = dy_r * dy_r;
    // Both squares stay below 2^18 because the offsets lie in -256..510.
    sqx_nxt = px[rcam_pkg::SQ_W-1:0];
    sqy_nxt = py[rcam_pkg::SQ_W-1:0];
  end

  always_comb begin
    sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};
    c_data_nxt.radc = {1'b0, sum_nxt, {rcam_pkg::FRAC_W{1'b0}}};
    c_data_nxt.rem  = '0;
    c_data_nxt.root = '0;
    c_data_nxt.base = b_base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= take;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    a_base_r <= a_base_nxt;
    sqx_r    <= sqx_nxt;
    sqy_r    <= sqy_nxt;
    b_base_r <= a_base_r;
    c_data_r <= c_data_nxt;
  end

  assign ctl_o.valid = c_valid_r;
  assign data_o      = c_data_r;

endmodule

// ===== sv/rcam_sqrt_cell.sv =====
// One digit step of the pipelined floor square root.
module rcam_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rcam_pkg::slot_ctl_t   ctl_i,
  input  rcam_pkg::cell_data_t  data_i,
  output rcam_pkg::slot_ctl_t   ctl_o,
  output rcam_pkg::cell_data_t  data_o
);

  logic [rcam_pkg::REM_W+1:0] cur, trial, diff;
  logic                       ge;
  rcam_pkg::slot_ctl_t        ctl_r;
  rcam_pkg::cell_data_t       data_r, data_nxt;

  always_comb begin
    // Bring down the next two radicand bits and try root*4 + 1.
    cur   = {data_i.rem, data_i.radc[rcam_pkg::RADC_W-1 -: 2]};
    trial = {2'b00, data_i.root, 2'b01};
    diff  = cur - trial;
    ge    = (cur >= trial);

    data_nxt.radc = {data_i.radc[rcam_pkg::RADC_W-3:0], 2'b00};
    data_nxt.rem  = ge ? diff[rcam_pkg::REM_W-1:0] : cur[rcam_pkg::REM_W-1:0];
    data_nxt.root = {data_i.root[rcam_pkg::ROOT_W-2:0], ge};
    data_nxt.base = data_i.base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign ctl_o  = ctl_r;
  assign data_o = data_r;

endmodule

// ===== sv/rounded_corner_alpha_mask_unit.sv =====
// Top level of the rounded-corner alpha mask unit: front stages, root chain, clamp.
// Throughput: one pixel per clock; busy is always low, so a new transfer may follow every cycle.
// An accepted pixel passes three front stages, 18 square-root cells and the output register.
// Reset (synchronous, rst_n low) empties the pipeline and sets the radius to 16.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rounded_corner_alpha_mask_unit #(
  parameter int MAX_RADIUS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcam_pkg::COORD_W-1:0]      in_col,
  input  logic [rcam_pkg::COORD_W-1:0]      in_row,
  output logic                              out_valid,
  output logic [rcam_pkg::ALPHA_W-1:0]      out_alpha,
  input  logic                              cfg_we,
  input  logic [rcam_pkg::RAD_CFG_W-1:0]    cfg_data
);

  // The radius register is only 9 bits wide, so a limit at or above its
  // largest value never clips anything.
  localparam int RadMaxVal = (1 << rcam_pkg::RAD_CFG_W) - 1;
  localparam int RadClip   = (MAX_RADIUS < RadMaxVal) ? MAX_RADIUS : RadMaxVal;
  localparam int ChainLat  = rcam_pkg::N_CELLS + 4;

  logic [rcam_pkg::RAD_CFG_W-1:0] radius_r;
  logic [rcam_pkg::RAD_CFG_W-1:0] r_eff;
  logic                           take;

  // Slot 0 is the output of the front stages; slot k is the output of cell k-1.
  rcam_pkg::slot_ctl_t  ctl   [rcam_pkg::N_CELLS+1];
  rcam_pkg::cell_data_t data  [rcam_pkg::N_CELLS+1];

  logic signed [rcam_pkg::ROOT_W:0] diff;
  logic [rcam_pkg::ALPHA_W-1:0]     alpha_nxt;
  logic [rcam_pkg::ALPHA_W-1:0]     out_alpha_r;
  logic                             out_valid_r;

  // Every transfer is taken at once; the pipeline never backs up.
  assign busy = 1'b0;
  assign take = start && !busy;

  // Configuration is to be written only while the unit is idle, so every
  // stage may read the live register; the block has no check for this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 9'd16;
    end else if (cfg_we) begin
      radius_r <= cfg_data;
    end
  end

  // Radius above the supported maximum saturates to it.
  assign r_eff = (radius_r > rcam_pkg::RAD_CFG_W'(RadClip)) ?
                 rcam_pkg::RAD_CFG_W'(RadClip) : radius_r;

  // Offsets, squares and the shifted sum take three register stages.
  rcam_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .col    (in_col),
    .row    (in_row),
    .r_eff  (r_eff),
    .ctl_o  (ctl[0]),
    .data_o (data[0])
  );

  // The floor square root runs down a row of identical cells, each one
  // resolving one root bit from two radicand bits and handing the partial
  // remainder and root to its neighbor on the next clock.
  for (genvar k = 0; k < rcam_pkg::N_CELLS; k++) begin : g_cell
    rcam_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl[k]),
      .data_i (data[k]),
      .ctl_o  (ctl[k+1]),
      .data_o (data[k+1])
    );
  end

  // Alpha is 127 + (radius << 8) minus the 10.8 distance, clamped to 0..255.
  always_comb begin
    diff = $signed({2'b00, data[rcam_pkg::N_CELLS].base})
         - $signed({1'b0, data[rcam_pkg::N_CELLS].root});
    if (diff[rcam_pkg::ROOT_W]) begin
      alpha_nxt = '0;
    end else if (diff > $signed({{(rcam_pkg::ROOT_W-rcam_pkg::ALPHA_W+1){1'b0}},
                                 rcam_pkg::ALPHA_MAX})) begin
      alpha_nxt = rcam_pkg::ALPHA_MAX;
    end else begin
      alpha_nxt = diff[rcam_pkg::ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[rcam_pkg::N_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r <= alpha_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;

  // Each accepted pixel comes out exactly once, a fixed number of cycles later.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##ChainLat out_valid)
    else $error("accepted pixel did not produce a result on time");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, ChainLat))
    else $error("result appeared without a matching accepted pixel");

  // The final remainder of a floor square root never exceeds twice the root.
  a_root_rem : assert property (@(posedge clk) disable iff (!rst_n)
    ctl[rcam_pkg::N_CELLS].valid |->
      (data[rcam_pkg::N_CELLS].rem <= {1'b0, data[rcam_pkg::N_CELLS].root, 1'b0}))
    else $error("square-root remainder out of range");

endmodule

// ===== dv/rounded_corner_alpha_mask_unit_test.sv =====
// Self-checking testbench for the rounded-corner alpha mask unit.
`timescale 1ns / 1ps

module rounded_corner_alpha_mask_unit_test;

  localparam int MAX_RADIUS = 256;
  // Quiet cycles allowed before the run is declared hung. The worst correct gap is
  // one idle burst plus a full pipeline drain plus a register write, far below this.
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_PIXELS = 155;
  localparam int DRAIN_CYCLES = 40;

  // Scoreboard: keeps its own copy of the radius register and predicts the alpha
  // of every accepted pixel, in transfer order, since the block never reorders.
  class alpha_scoreboard;
    int unsigned radius;
    logic [rcam_pkg::ALPHA_W-1:0] alpha_q[$];
    int errors;

    function new();
      radius = 16;
      errors = 0;
    endfunction

    function void note_radius(logic [rcam_pkg::RAD_CFG_W-1:0] value);
      radius = value;
    endfunction

    // Floor square root by binary search; the loop keeps lo*lo <= n < hi*hi.
    function longint floor_root(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = longint'(1) << 20;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid <= n) lo = mid;
        else hi = mid;
      end
      return lo;
    endfunction

    function logic [rcam_pkg::ALPHA_W-1:0] coverage_alpha(
        logic [rcam_pkg::COORD_W-1:0] col, logic [rcam_pkg::COORD_W-1:0] row);
      longint r, cx, cy, dx, dy, dist_fp, a;
      r = radius;
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      cx = col;
      cy = row;
      // The circle center sits at (r-1, r-1); a radius of zero puts it at (-1, -1).
      dx = (r - 1) - cx;
      dy = (r - 1) - cy;
      dist_fp = floor_root((dx * dx + dy * dy) << rcam_pkg::FRAC_W);
      a = longint'(rcam_pkg::ALPHA_BIAS) + (r << 8) - dist_fp;
      if (a < 0) a = 0;
      if (a > longint'(rcam_pkg::ALPHA_MAX)) a = longint'(rcam_pkg::ALPHA_MAX);
      return a[rcam_pkg::ALPHA_W-1:0];
    endfunction

    function void note_pixel(logic [rcam_pkg::COORD_W-1:0] col,
                             logic [rcam_pkg::COORD_W-1:0] row);
      alpha_q.push_back(coverage_alpha(col, row));
    endfunction

    function void check_alpha(logic [rcam_pkg::ALPHA_W-1:0] got);
      logic [rcam_pkg::ALPHA_W-1:0] want;
      if (alpha_q.size() == 0) begin
        $error("unexpected result transfer: alpha %0d with nothing outstanding", got);
        errors++;
        return;
      end
      want = alpha_q.pop_front();
      if (got !== want) begin
        $error("alpha mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return alpha_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [rcam_pkg::COORD_W-1:0] in_col = '0;
  logic [rcam_pkg::COORD_W-1:0] in_row = '0;
  logic out_valid;
  logic [rcam_pkg::ALPHA_W-1:0] out_alpha;
  logic cfg_we = 1'b0;
  logic [rcam_pkg::RAD_CFG_W-1:0] cfg_data = '0;

  alpha_scoreboard sb = new();
  int quiet_cycles = 0;

  rounded_corner_alpha_mask_unit #(
    .MAX_RADIUS(MAX_RADIUS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_col(in_col),
    .in_row(in_row),
    .out_valid(out_valid),
    .out_alpha(out_alpha),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Results cannot be held off, so every strobed cycle is a completed transfer.
  // Outputs are read right at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_alpha(out_alpha);
    end
  end

  // Watchdog: any transfer on either side restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rounded_corner_alpha_mask_unit_test: errors");
      $finish;
    end
  end

  // Present one pixel and hold it until the block takes it. The caller follows
  // with another pixel, an idle burst, a radius change or the end of the run, so
  // start changes at most once per edge.
  task automatic drive_pixel(input logic [rcam_pkg::COORD_W-1:0] col,
                             input logic [rcam_pkg::COORD_W-1:0] row);
    start <= 1'b1;
    in_col <= col;
    in_row <= row;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(col, row);
  endtask

  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The radius may only change with the pipeline empty: stop issuing, wait for
  // every outstanding result, then write the register for a single edge.
  task automatic set_radius(input logic [rcam_pkg::RAD_CFG_W-1:0] value);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.note_radius(value);
  endtask

  initial begin
    int r_cfg, r_eff, kind, dx, dy, row_i;
    bit gaps_on;
    logic [rcam_pkg::COORD_W-1:0] col_v, row_v;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset radius of 16: the mask corners, the circle
    // center, pixels outside the mask and alternating bit patterns.
    drive_pixel(8'd0, 8'd0);
    drive_pixel(8'd255, 8'd255);
    drive_pixel(8'd15, 8'd15);
    drive_pixel(8'd16, 8'd16);
    drive_pixel(8'd15, 8'd0);
    drive_pixel(8'd0, 8'd15);
    drive_pixel(8'd255, 8'd0);
    drive_pixel(8'd0, 8'd255);
    drive_pixel(8'd170, 8'd85);
    drive_pixel(8'd85, 8'd170);
    drive_pixel(8'd4, 8'd11);

    // Radius zero moves the center to (-1, -1) and every pixel gets alpha 0.
    set_radius(9'd0);
    drive_pixel(8'd0, 8'd0);
    drive_pixel(8'd255, 8'd255);
    drive_pixel(8'd1, 8'd0);

    // All-ones register value: saturates to the largest radius.
    set_radius(9'd511);
    drive_pixel(8'd0, 8'd0);
    drive_pixel(8'd255, 8'd255);
    drive_pixel(8'd170, 8'd85);
    drive_pixel(8'd128, 8'd0);

    set_radius(9'd1);
    drive_pixel(8'd0, 8'd0);
    drive_pixel(8'd1, 8'd1);

    set_radius(9'd256);
    drive_pixel(8'd255, 8'd255);
    drive_pixel(8'd0, 8'd0);

    // Random phases, each under its own radius. Most pixels fall in the mask or
    // right on the circle's rim, where the antialiasing is worked hardest.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: r_cfg = 8;
        1: r_cfg = 1;
        2: r_cfg = 256;
        3: r_cfg = 511;
        4: r_cfg = 2;
        5: r_cfg = $urandom_range(3, 40);
        6: r_cfg = $urandom_range(41, 256);
        7: r_cfg = 0;
        8: r_cfg = $urandom_range(257, 511);
        default: r_cfg = $urandom_range(1, 64);
      endcase
      set_radius(r_cfg[rcam_pkg::RAD_CFG_W-1:0]);
      r_eff = (r_cfg > MAX_RADIUS) ? MAX_RADIUS : r_cfg;
      gaps_on = 1'b0;

      for (int i = 0; i < PHASE_PIXELS; i++) begin
        // Idle bursts come and go in stretches; the final phase runs back to back.
        if (i % 40 == 0) gaps_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
        if (gaps_on && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 14));

        kind = $urandom_range(0, 7);
        if (r_eff == 0 || kind >= 6) begin
          col_v = rcam_pkg::COORD_W'($urandom_range(0, 255));
          row_v = rcam_pkg::COORD_W'($urandom_range(0, 255));
        end else if (kind >= 3) begin
          col_v = rcam_pkg::COORD_W'($urandom_range(0, r_eff - 1));
          row_v = rcam_pkg::COORD_W'($urandom_range(0, r_eff - 1));
        end else begin
          // Pick a column, then a row within one pixel of the circle through it.
          col_v = rcam_pkg::COORD_W'($urandom_range(0, r_eff - 1));
          dx = r_eff - 1 - int'(col_v);
          dy = int'(sb.floor_root(longint'(r_eff * r_eff - dx * dx)));
          row_i = r_eff - 1 - dy + int'($urandom_range(0, 2)) - 1;
          if (row_i < 0) row_i = 0;
          if (row_i > 255) row_i = 255;
          row_v = row_i[rcam_pkg::COORD_W-1:0];
        end
        if ($urandom_range(0, 1) == 1) drive_pixel(col_v, row_v);
        else drive_pixel(row_v, col_v);
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Linger past the pipeline depth so that a stray extra result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("rounded_corner_alpha_mask_unit_test: clean");
    end else begin
      $display("rounded_corner_alpha_mask_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rcam_pkg.sv
sv/rcam_front.sv
sv/rcam_sqrt_cell.sv
sv/rounded_corner_alpha_mask_unit.sv
dv/rounded_corner_alpha_mask_unit_test.sv
